// File: design/i2r_pkg.sv
// Shared types, token kind codes and precedence table of the infix to RPN converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2r_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned HANDLE_BITS     = 16;

  // Token kinds
  localparam logic [3:0] KIND_OPERAND   = 4'd0;
  localparam logic [3:0] KIND_SEPARATOR = 4'd1;
  localparam logic [3:0] KIND_ASSIGN    = 4'd2;
  localparam logic [3:0] KIND_OR        = 4'd3;
  localparam logic [3:0] KIND_AND       = 4'd4;
  localparam logic [3:0] KIND_XOR       = 4'd5;
  localparam logic [3:0] KIND_ADD       = 4'd6;
  localparam logic [3:0] KIND_SUB       = 4'd7;
  localparam logic [3:0] KIND_MUL       = 4'd8;
  localparam logic [3:0] KIND_DIV       = 4'd9;
  localparam logic [3:0] KIND_MOD       = 4'd10;
  localparam logic [3:0] KIND_OPEN      = 4'd11;
  localparam logic [3:0] KIND_FUNC      = 4'd12;
  localparam logic [3:0] KIND_CLOSE     = 4'd13;
  localparam logic [3:0] KIND_OTHER     = 4'd14;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_SYMBOL   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [3:0]             cmd;
    logic [HANDLE_BITS-1:0] token_handle;
    logic                   last_token;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             out_kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   run_last;
    logic                   expr_done;
    logic [1:0]             error_code;
  } out_item_t;

  // One operator stack entry
  typedef struct packed {
    logic [3:0]             kind;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

  // Operator precedence; parentheses and functions rank lowest
  function automatic logic [2:0] prec_of(input logic [3:0] kind);
    logic [2:0] p;
    unique case (kind)
      KIND_ASSIGN:                  p = 3'd1;
      KIND_OR:                      p = 3'd2;
      KIND_AND:                     p = 3'd3;
      KIND_XOR:                     p = 3'd4;
      KIND_ADD, KIND_SUB:           p = 3'd5;
      KIND_MUL, KIND_DIV, KIND_MOD: p = 3'd6;
      default:                      p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: design/i2r_cell.sv
// One operator stack cell: holds one entry, loads from the upper or lower neighbor.
// Depends on i2r_pkg.
`default_nettype none

module i2r_cell
  import i2r_pkg::*;
(
  input  wire logic     clk_i,
  input  wire cell_op_e op_i,
  input  wire entry_t   upper_i,
  input  wire entry_t   lower_i,
  output      entry_t   entry_o
);

  entry_t entry_q;

  // Push shifts entries down, pop shifts them up
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_PUSH: entry_q <= upper_i;
      CELL_POP:  entry_q <= lower_i;
      default:   entry_q <= entry_q;
    endcase
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: design/i2r_stack.sv
// Operator stack built as a chain of cells with the top in cell 0, plus a fill count.
// Depends on i2r_pkg and i2r_cell.
`default_nettype none

module i2r_stack
  import i2r_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stack_ctrl_t ctrl_i,
  input  wire entry_t      push_data_i,
  output      entry_t      top_o,
  output      stack_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  cell_op_e        cell_op;
  entry_t          cell_data [STACK_DEPTH];

  always_comb begin
    priority if (ctrl_i.push) begin
      cell_op = CELL_PUSH;
    end else if (ctrl_i.pop) begin
      cell_op = CELL_POP;
    end else begin
      cell_op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t upper, lower;
    if (i == 0) begin : g_top
      assign upper = push_data_i;
    end else begin : g_mid
      assign upper = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign lower = '0;
    end else begin : g_body
      assign lower = cell_data[i+1];
    end
    i2r_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .upper_i (upper),
      .lower_i (lower),
      .entry_o (cell_data[i])
    );
  end

  always_comb begin
    priority if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o        = cell_data[0];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(STACK_DEPTH));

endmodule

`default_nettype wire

// File: design/infix_to_rpn_converter_core.sv
// Infix to reverse Polish token converter (shunting yard) with a cell-chain operator stack.
// Depends on i2r_pkg and i2r_stack.
//
// Usage:
//   in channel  : one infix token per item (kind, handle, last-of-expression flag).
//   out channel : tokens in reverse Polish order; run_last marks the final result of
//                 an input item, expr_done the end (or abort) of an expression.
//   Sequencing  : an item is taken in ST_IDLE or ST_FINISH and worked on in ST_MAIN (and
//                 ST_FUNC after a dropped open parenthesis), which pops or drops stack
//                 entries one at a time; an item marked last then passes ST_FLUSH, and the
//                 item is finalized in ST_FINISH, which also takes the next item. A state
//                 that finds an error queues the error result and goes straight to ST_FINISH.
//                 The stack moves by one entry per push or pop through the cell chain.
//   Output      : a result leaves through a one-entry holding register and then the output
//                 register; it moves on from the holding register when the next result is
//                 queued or when its item is finalized.
//   Errors      : give one error result; later items up to the one marked last are taken
//                 and dropped.
//   Reset       : empties the stack, clears the discard mode and the output; no clearing pass.
//   Stall       : while out_ready_i is low the held results wait; the block stops popping
//                 once both holding stages are full, and accepts the next item only after
//                 the current one is finalized.
`default_nettype none

module infix_to_rpn_converter_core
  import i2r_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_item_o
);

  // Control states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAIN   = 3'd1;
  localparam logic [2:0] ST_FUNC   = 3'd2;
  localparam logic [2:0] ST_FLUSH  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [3:0]             kind_q, kind_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   last_q, last_d;
  logic [1:0]             err_q, err_d;
  logic                   discard_q, discard_d;
  out_item_t              pend_q, pend_d;
  logic                   pend_v_q, pend_v_d;
  out_item_t              out_q, out_d;
  logic                   out_v_q, out_v_d;

  stack_ctrl_t stk_ctrl;
  stack_stat_t stk_stat;
  entry_t      top;
  entry_t      push_data;

  logic      out_free, emit_ok, fin_ok, accept;
  logic      emit_req;
  out_item_t emit_item;
  out_item_t pop_item;

  i2r_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (stk_ctrl),
    .push_data_i (push_data),
    .top_o       (top),
    .stat_o      (stk_stat)
  );

  assign push_data = '{kind: kind_q, handle: handle_q};
  assign pop_item  = '{out_kind: top.kind, out_handle: top.handle, run_last: 1'b0,
                       expr_done: 1'b0, error_code: ERR_NONE};

  // The output register frees up this cycle if empty or being taken
  assign out_free = !out_v_q || out_ready_i;
  // A new result may enter the holding register
  assign emit_ok  = !pend_v_q || out_free;
  // Finalizing needs the output register only if something goes out
  assign fin_ok   = !(pend_v_q || last_q) || out_free;

  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && fin_ok);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    handle_d  = handle_q;
    last_d    = last_q;
    err_d     = err_q;
    discard_d = discard_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !out_ready_i;
    stk_ctrl  = '0;
    emit_req  = 1'b0;
    emit_item = pop_item;

    unique case (state_q)
      ST_MAIN: begin
        priority if (kind_q == KIND_OPERAND) begin
          if (emit_ok) begin
            emit_req  = 1'b1;
            emit_item = '{out_kind: KIND_OPERAND, out_handle: handle_q, run_last: 1'b0,
                          expr_done: 1'b0, error_code: ERR_NONE};
            state_d   = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else if (kind_q == KIND_SEPARATOR) begin
          // Pop down to the nearest open parenthesis, drop the separator
          if (!stk_stat.empty && top.kind != KIND_OPEN) begin
            if (emit_ok) begin
              emit_req     = 1'b1;
              stk_ctrl.pop = 1'b1;
            end
          end else begin
            state_d = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else if (kind_q >= KIND_ASSIGN && kind_q <= KIND_MOD) begin
          priority if (!stk_stat.empty && prec_of(kind_q) <= prec_of(top.kind)) begin
            if (emit_ok) begin
              emit_req     = 1'b1;
              stk_ctrl.pop = 1'b1;
            end
          end else if (stk_stat.full) begin
            err_d = ERR_OVERFLOW;
          end else begin
            stk_ctrl.push = 1'b1;
            state_d       = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else if (kind_q == KIND_OPEN || kind_q == KIND_FUNC) begin
          if (stk_stat.full) begin
            err_d = ERR_OVERFLOW;
          end else begin
            stk_ctrl.push = 1'b1;
            state_d       = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else if (kind_q == KIND_CLOSE) begin
          priority if (!stk_stat.empty && top.kind != KIND_OPEN) begin
            if (emit_ok) begin
              emit_req     = 1'b1;
              stk_ctrl.pop = 1'b1;
            end
          end else if (stk_stat.empty) begin
            err_d = ERR_PAREN;
          end else begin
            // Drop the matching open parenthesis
            stk_ctrl.pop = 1'b1;
            state_d      = ST_FUNC;
          end
        end else begin
          err_d = ERR_SYMBOL;
        end
      end

      ST_FUNC: begin
        // Emit a function sitting right under the dropped parenthesis
        if (!stk_stat.empty && top.kind == KIND_FUNC) begin
          if (emit_ok) begin
            emit_req     = 1'b1;
            stk_ctrl.pop = 1'b1;
            state_d      = last_q ? ST_FLUSH : ST_FINISH;
          end
        end else begin
          state_d = last_q ? ST_FLUSH : ST_FINISH;
        end
      end

      ST_FLUSH: begin
        priority if (stk_stat.empty) begin
          state_d = ST_FINISH;
        end else if (top.kind == KIND_OPEN) begin
          // Unmatched open parenthesis: report its own handle
          err_d    = ERR_PAREN;
          handle_d = top.handle;
        end else if (emit_ok) begin
          emit_req     = 1'b1;
          stk_ctrl.pop = 1'b1;
        end
      end

      ST_FINISH: begin
        if (fin_ok) begin
          state_d = ST_IDLE;
          priority if (pend_v_q) begin
            out_d           = pend_q;
            out_d.run_last  = 1'b1;
            out_d.expr_done = last_q || (err_q != ERR_NONE);
            out_v_d         = 1'b1;
            pend_v_d        = 1'b0;
          end else if (last_q) begin
            // Empty end: emit an end marker
            out_d   = '{out_kind: KIND_OPEN, out_handle: '0, run_last: 1'b1,
                        expr_done: 1'b1, error_code: ERR_NONE};
            out_v_d = 1'b1;
          end else begin
            out_d = out_q;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Error found this cycle: queue the error result, empty the stack
    if (err_d != ERR_NONE && err_q == ERR_NONE && state_q != ST_FINISH
        && state_q != ST_IDLE) begin
      if (emit_ok) begin
        emit_req       = 1'b1;
        emit_item      = '{out_kind: KIND_OPERAND, out_handle: handle_d, run_last: 1'b0,
                           expr_done: 1'b0, error_code: err_d};
        stk_ctrl.clear = 1'b1;
        discard_d      = !last_q;
        state_d        = ST_FINISH;
      end else begin
        // Hold until the holding register can take the error result
        err_d    = err_q;
        handle_d = handle_q;
      end
    end

    if (emit_req) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = emit_item;
      pend_v_d = 1'b1;
    end

    if (accept) begin
      if (discard_q) begin
        // Drop items of an aborted expression
        if (in_item_i.last_token) begin
          discard_d = 1'b0;
        end
        state_d = ST_IDLE;
      end else begin
        kind_d   = in_item_i.cmd;
        handle_d = in_item_i.token_handle;
        last_d   = in_item_i.last_token;
        err_d    = ERR_NONE;
        state_d  = ST_MAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      err_q     <= ERR_NONE;
      discard_q <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      err_q     <= err_d;
      discard_q <= discard_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    handle_q <= handle_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: tb/infix_to_rpn_converter_core_test.sv
// Testbench for infix_to_rpn_converter_core: token streams in, RPN token stream checked out.
// Depends on i2r_pkg and the converter core; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module infix_to_rpn_converter_core_test;
  import i2r_pkg::*;

  localparam int unsigned STACK_LIMIT    = STACK_DEPTH_DEF;
  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned ITEM_GOAL      = 280;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Token kinds the package leaves unnamed
  localparam logic [3:0] KIND_RESERVED = 4'd15;
  localparam logic [3:0] KIND_LAST     = 4'd15;

  // Scoreboard: runs its own shunting-yard stack on every accepted token and
  // keeps the RPN results still owed by the block, oldest first.
  class rpn_scoreboard;
    entry_t      op_stack[STACK_LIMIT];
    int unsigned depth;
    bit          discarding;
    out_item_t   burst[$];
    out_item_t   rpn_due[$];
    int unsigned failures, taken, ignored, checked, error_results;

    function new();
      depth = 0;
      discarding = 1'b0;
      failures = 0;
      taken = 0;
      ignored = 0;
      checked = 0;
      error_results = 0;
    endfunction

    function int unsigned rank(logic [3:0] kind);
      case (kind)
        KIND_ASSIGN:                 return 1;
        KIND_OR:                     return 2;
        KIND_AND:                    return 3;
        KIND_XOR:                    return 4;
        KIND_ADD, KIND_SUB:          return 5;
        KIND_MUL, KIND_DIV, KIND_MOD: return 6;
        default:                     return 0;
      endcase
    endfunction

    function void emit(logic [3:0] kind, logic [HANDLE_BITS-1:0] hnd, logic [1:0] err);
      out_item_t r;
      r.out_kind = kind;
      r.out_handle = hnd;
      r.run_last = 1'b0;
      r.expr_done = 1'b0;
      r.error_code = err;
      burst.push_back(r);
    endfunction

    function void pop_top();
      entry_t t;
      t = op_stack[depth-1];
      emit(t.kind, t.handle, ERR_NONE);
      depth--;
    endfunction

    function bit push_entry(logic [3:0] kind, logic [HANDLE_BITS-1:0] hnd);
      if (depth >= STACK_LIMIT) return 1'b0;
      op_stack[depth].kind = kind;
      op_stack[depth].handle = hnd;
      depth++;
      return 1'b1;
    endfunction

    // Convert one accepted token and queue the results it owes.
    function void take_token(in_item_t tok);
      logic [3:0]             kind;
      logic [HANDLE_BITS-1:0] hnd, err_hnd;
      logic [1:0]             err;
      bit                     last;
      out_item_t              tail;
      kind = tok.cmd;
      hnd = tok.token_handle;
      last = tok.last_token;
      err = ERR_NONE;
      err_hnd = hnd;
      if (discarding) begin
        if (last) discarding = 1'b0;
        ignored++;
        return;
      end
      taken++;
      burst.delete();
      if (kind == KIND_OPERAND) begin
        emit(kind, hnd, ERR_NONE);
      end else if (kind == KIND_SEPARATOR) begin
        while (depth > 0 && op_stack[depth-1].kind != KIND_OPEN) pop_top();
      end else if (kind <= KIND_MOD) begin
        while (depth > 0 && rank(kind) <= rank(op_stack[depth-1].kind)) pop_top();
        if (!push_entry(kind, hnd)) err = ERR_OVERFLOW;
      end else if (kind == KIND_OPEN || kind == KIND_FUNC) begin
        if (!push_entry(kind, hnd)) err = ERR_OVERFLOW;
      end else if (kind == KIND_CLOSE) begin
        while (depth > 0 && op_stack[depth-1].kind != KIND_OPEN) pop_top();
        if (depth == 0) begin
          err = ERR_PAREN;
        end else begin
          depth--;
          if (depth > 0 && op_stack[depth-1].kind == KIND_FUNC) pop_top();
        end
      end else begin
        err = ERR_SYMBOL;
      end
      // Flush at end of expression; a leftover open paren aborts with its own handle
      if (err == ERR_NONE && last) begin
        while (depth > 0 && err == ERR_NONE) begin
          if (op_stack[depth-1].kind == KIND_OPEN) begin
            err = ERR_PAREN;
            err_hnd = op_stack[depth-1].handle;
          end else begin
            pop_top();
          end
        end
      end
      if (err != ERR_NONE) begin
        emit(KIND_OPERAND, err_hnd, err);
        depth = 0;
        discarding = !last;
        error_results++;
      end
      if (burst.size() == 0 && last) emit(KIND_OPEN, '0, ERR_NONE);
      if (burst.size() > 0) begin
        tail = burst.pop_back();
        tail.run_last = 1'b1;
        tail.expr_done = last || (err != ERR_NONE);
        burst.push_back(tail);
      end
      foreach (burst[i]) rpn_due.push_back(burst[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (rpn_due.size() == 0) begin
        $error("unexpected result: kind %0d handle %h", got.out_kind, got.out_handle);
        failures++;
        return;
      end
      want = rpn_due.pop_front();
      checked++;
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
        failures++;
      end
      if (got.out_handle !== want.out_handle) begin
        $error("out_handle: expected %h, got %h", want.out_handle, got.out_handle);
        failures++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
        failures++;
      end
      if (got.expr_done !== want.expr_done) begin
        $error("expr_done: expected %0d, got %0d", want.expr_done, got.expr_done);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        failures++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  rpn_scoreboard sb;
  in_item_t      script[$];
  int unsigned   send_idle_pct = 36;
  int unsigned   recv_stall_pct = 88;
  int unsigned   idle_cycles = 0;

  infix_to_rpn_converter_core #(
    .STACK_DEPTH(STACK_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Receiver: redraw ready every falling edge from the current stall rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: sample both handshakes at the rising edge, before the block updates.
  // The watchdog counts edges with no item moving on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_token(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Append one token with a random handle; the last flag is set afterwards
  function automatic void add_tok(logic [3:0] kind);
    in_item_t t;
    t.cmd = kind;
    t.token_handle = HANDLE_BITS'($urandom_range(16'hFFFF));
    t.last_token = 1'b0;
    script.push_back(t);
  endfunction

  function automatic void mark_end();
    in_item_t t;
    t = script.pop_back();
    t.last_token = 1'b1;
    script.push_back(t);
  endfunction

  // Well-formed expression: terms joined by random binary operators
  function automatic void gen_expr(int lvl);
    gen_term(lvl);
    repeat ($urandom_range(3)) begin
      add_tok(4'($urandom_range(KIND_ASSIGN, KIND_MOD)));
      gen_term(lvl);
    end
  endfunction

  // Term: operand, parenthesized expression, or function call with 0..3 arguments
  function automatic void gen_term(int lvl);
    int unsigned pick;
    pick = (lvl > 0) ? $urandom_range(5) : 0;
    if (pick <= 2) begin
      add_tok(KIND_OPERAND);
    end else if (pick == 3) begin
      add_tok(KIND_OPEN);
      gen_expr(lvl - 1);
      add_tok(KIND_CLOSE);
    end else begin
      add_tok(KIND_FUNC);
      add_tok(KIND_OPEN);
      if (pick == 4) begin
        gen_expr(lvl - 1);
        repeat ($urandom_range(2)) begin
          add_tok(KIND_SEPARATOR);
          gen_expr(lvl - 1);
        end
      end
      add_tok(KIND_CLOSE);
    end
  endfunction

  // Hold valid and payload until the block takes the item; idle before it at random
  task automatic send_item(input in_item_t tok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= tok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic play_script();
    while (script.size() > 0) send_item(script.pop_front());
  endtask

  initial begin
    int unsigned kind_sel, n, idx;
    in_item_t    t;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a = b | c & d ^ e + f - g, handles at both extremes
    t.cmd = KIND_OPERAND;
    t.token_handle = '0;
    t.last_token = 1'b0;
    script.push_back(t);
    t.cmd = KIND_ASSIGN;
    t.token_handle = '1;
    script.push_back(t);
    add_tok(KIND_OPERAND);
    add_tok(KIND_OR);
    add_tok(KIND_OPERAND);
    add_tok(KIND_AND);
    add_tok(KIND_OPERAND);
    add_tok(KIND_XOR);
    add_tok(KIND_OPERAND);
    add_tok(KIND_ADD);
    add_tok(KIND_OPERAND);
    add_tok(KIND_SUB);
    add_tok(KIND_OPERAND);
    mark_end();
    // f(a, b) * c / d % e: function popped right after its close paren
    add_tok(KIND_FUNC);
    add_tok(KIND_OPEN);
    add_tok(KIND_OPERAND);
    add_tok(KIND_SEPARATOR);
    add_tok(KIND_OPERAND);
    add_tok(KIND_CLOSE);
    add_tok(KIND_MUL);
    add_tok(KIND_OPERAND);
    add_tok(KIND_DIV);
    add_tok(KIND_OPERAND);
    add_tok(KIND_MOD);
    add_tok(KIND_OPERAND);
    mark_end();
    // Unmatched close paren, open paren left at flush, empty end marker
    add_tok(KIND_CLOSE);
    mark_end();
    add_tok(KIND_OPEN);
    mark_end();
    add_tok(KIND_SEPARATOR);
    mark_end();
    // Unknown kinds; the first one mid-expression drops the rest up to last
    add_tok(KIND_OTHER);
    add_tok(KIND_OPERAND);
    add_tok(KIND_OPERAND);
    mark_end();
    add_tok(KIND_RESERVED);
    mark_end();
    play_script();

    // Random: mostly well-formed expressions, mixed with broken ones, noise and deep nesting
    while (sb.taken + sb.ignored < ITEM_GOAL) begin
      if (sb.taken + sb.ignored >= 190) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (sb.taken + sb.ignored >= 100) begin
        send_idle_pct = 88;
        recv_stall_pct = 36;
      end
      kind_sel = $urandom_range(99);
      if (kind_sel < 85) begin
        gen_expr($urandom_range(2));
        // Corrupt one token, and sometimes cut the tail off
        if (kind_sel >= 70) begin
          idx = $urandom_range(script.size() - 1);
          t = script[idx];
          t.cmd = 4'($urandom_range(KIND_LAST));
          script[idx] = t;
          if ($urandom_range(1)) begin
            n = $urandom_range(script.size() - 1);
            while (script.size() > n + 1) void'(script.pop_back());
          end
        end
      end else if (kind_sel < 95) begin
        repeat ($urandom_range(1, 8)) begin
          add_tok(4'($urandom_range(KIND_LAST)));
          t = script.pop_back();
          t.last_token = 1'($urandom_range(1));
          script.push_back(t);
        end
      end else begin
        // Nest up to and past the stack depth to hit overflow and full-stack pops
        n = $urandom_range(STACK_LIMIT - 3, STACK_LIMIT + 1);
        repeat (n) add_tok(KIND_OPEN);
        add_tok(KIND_OPERAND);
        if ($urandom_range(1)) begin
          add_tok(KIND_ADD);
          add_tok(KIND_OPERAND);
        end
        repeat ($urandom_range(n)) add_tok(KIND_CLOSE);
      end
      mark_end();
      play_script();
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then watch for strays
    while (sb.rpn_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d tokens and dropped %0d after errors.", sb.taken, sb.ignored);
    $display("Checked %0d RPN results, %0d of them error results.", sb.checked,
             sb.error_results);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
